// ===== hdl/md2_hash_engine_macros.svh =====
// assertion macros shared by the md2 hash engine
// expects aclk and aresetn in the scope of each use
`ifndef MD2_HASH_ENGINE_MACROS_SVH
`define MD2_HASH_ENGINE_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define MD2_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while reset is held
`define MD2_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/md2_pkg.sv =====
// md2 package: datapath command codes, controller/datapath structs, pi substitution table
// no dependencies
package md2_pkg;

    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
    localparam logic [OP_W-1:0] OP_PAD      = 4'd2;
    localparam logic [OP_W-1:0] OP_FOLD     = 4'd3;
    localparam logic [OP_W-1:0] OP_FILL_MSG = 4'd4;
    localparam logic [OP_W-1:0] OP_FILL_CK  = 4'd5;
    localparam logic [OP_W-1:0] OP_ROUND    = 4'd6;
    localparam logic [OP_W-1:0] OP_EMIT     = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR    = 4'd8;

    localparam logic [4:0] LAST_ROUND = 5'd17;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            step_last;
        logic [4:0]      round_idx;
    } md2_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic out_free;
    } md2_status_t;

    localparam logic [7:0] PI_SUBST [0:255] = '{
        8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
        8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
        8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
        8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
        8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
        8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
        8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
        8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
        8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
        8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
        8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
        8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
        8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
        8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
        8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
        8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
        8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
        8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
        8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
        8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
        8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
        8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
        8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
        8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
        8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
        8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
        8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
        8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
        8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
        8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
        8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
        8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
    };

endpackage

// ===== hdl/md2_ctrl.sv =====
// md2 controller: sequences load, pad, checksum fold, compression and digest output
// depends on md2_pkg for command codes and the command/status structs
module md2_ctrl
    import md2_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_byte_valid,
    input  logic        s_end_message,
    input  md2_status_t status,
    output md2_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_FOLD  = 3'd2;
    localparam logic [2:0] ST_FILL  = 3'd3;
    localparam logic [2:0] ST_ROUND = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_CLEAR = 3'd6;

    // which block the compression is working on
    localparam logic [1:0] PH_MSG = 2'd0;
    localparam logic [1:0] PH_PAD = 2'd1;
    localparam logic [1:0] PH_CK  = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [5:0] step_reg, step_next;
    logic [4:0] round_reg, round_next;
    logic       end_reg, end_next;

    // no transfer is taken while reset is held
    assign s_ready = aresetn && (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        round_next     = round_reg;
        end_next       = end_reg;
        cmd.op         = OP_NONE;
        cmd.step_last  = 1'b0;
        cmd.round_idx  = round_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                    if (s_byte_valid && status.fill_last) begin
                        end_next   = s_end_message;
                        phase_next = PH_MSG;
                        step_next  = 6'd0;
                        state_next = ST_FOLD;
                    end else if (s_end_message) begin
                        phase_next = PH_PAD;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.op     = OP_PAD;
                step_next  = 6'd0;
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.op    = OP_FOLD;
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd15) begin
                    step_next  = 6'd0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.op     = (phase_reg == PH_CK) ? OP_FILL_CK : OP_FILL_MSG;
                step_next  = 6'd0;
                round_next = 5'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.op        = OP_ROUND;
                cmd.step_last = (step_reg == 6'd47);
                step_next     = step_reg + 6'd1;
                if (step_reg == 6'd47) begin
                    step_next  = 6'd0;
                    round_next = round_reg + 5'd1;
                    if (round_reg == LAST_ROUND) begin
                        round_next = 5'd0;
                        case (phase_reg)
                            PH_MSG: begin
                                if (end_reg) begin
                                    phase_next = PH_PAD;
                                    state_next = ST_PAD;
                                end else begin
                                    state_next = ST_IDLE;
                                end
                            end
                            PH_PAD: begin
                                phase_next = PH_CK;
                                state_next = ST_FILL;
                            end
                            default: begin
                                state_next = ST_EMIT;
                            end
                        endcase
                    end
                end
            end
            ST_EMIT: begin
                // hand a byte over only when the output register can take it
                if (status.out_free) begin
                    cmd.op        = OP_EMIT;
                    cmd.step_last = (step_reg == 6'd15);
                    step_next     = step_reg + 6'd1;
                    if (step_reg == 6'd15) begin
                        step_next  = 6'd0;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.op     = OP_CLEAR;
                end_next   = 1'b0;
                phase_next = PH_MSG;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_MSG;
            step_reg  <= 6'd0;
            round_reg <= 5'd0;
            end_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
            round_reg <= round_next;
            end_reg   <= end_next;
        end
    end

endmodule

// ===== hdl/md2_datapath.sv =====
// md2 datapath: block buffer, checksum and 48-byte state as rotating registers, output register
// depends on md2_pkg for command codes, structs and the pi table
module md2_datapath
    import md2_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  md2_cmd_t    cmd,
    output md2_status_t status,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_digest_byte,
    output logic        m_last_byte
);

    logic [7:0] blk_reg [16];
    logic [7:0] blk_next [16];
    logic [7:0] ck_reg [16];
    logic [7:0] ck_next [16];
    logic [7:0] st_reg [48];
    logic [7:0] st_next [48];
    logic [7:0] chain_reg, chain_next;
    logic [7:0] t_reg, t_next;
    logic [3:0] fill_reg, fill_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_last_reg, out_last_next;

    logic [7:0] pad_val;
    logic [7:0] fold_val;
    logic [7:0] rnd_val;

    assign pad_val  = {3'b000, 5'd16 - {1'b0, fill_reg}};
    assign fold_val = ck_reg[0] ^ PI_SUBST[blk_reg[0] ^ chain_reg];
    assign rnd_val  = st_reg[0] ^ PI_SUBST[t_reg];

    assign status.fill_last = (fill_reg == 4'd15);
    assign status.out_free  = !out_valid_reg || m_ready;

    assign m_valid       = out_valid_reg;
    assign m_digest_byte = out_data_reg;
    assign m_last_byte   = out_last_reg;

    always_comb begin
        blk_next       = blk_reg;
        ck_next        = ck_reg;
        st_next        = st_reg;
        chain_next     = chain_reg;
        t_next         = t_reg;
        fill_next      = fill_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = m_ready ? 1'b0 : out_valid_reg;
        unique case (cmd.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                if (s_byte_valid) begin
                    blk_next[fill_reg] = s_data_byte;
                    fill_next          = fill_reg + 4'd1;
                end
            end
            OP_PAD: begin
                for (int j = 0; j < 16; j++) begin
                    if (4'(j) >= fill_reg) begin
                        blk_next[j] = pad_val;
                    end
                end
            end
            OP_FOLD: begin
                // one chained checksum step, both rows rotate back in place after a full turn
                for (int j = 0; j < 15; j++) begin
                    ck_next[j]  = ck_reg[j+1];
                    blk_next[j] = blk_reg[j+1];
                end
                ck_next[15]  = fold_val;
                blk_next[15] = blk_reg[0];
                chain_next   = fold_val;
            end
            OP_FILL_MSG: begin
                for (int j = 0; j < 16; j++) begin
                    st_next[16+j] = blk_reg[j];
                    st_next[32+j] = blk_reg[j] ^ st_reg[j];
                end
                t_next = 8'd0;
            end
            OP_FILL_CK: begin
                for (int j = 0; j < 16; j++) begin
                    st_next[16+j] = ck_reg[j];
                    st_next[32+j] = ck_reg[j] ^ st_reg[j];
                end
                t_next = 8'd0;
            end
            OP_ROUND: begin
                // one substitution per cycle, state rotates back in place after a full turn
                for (int j = 0; j < 47; j++) begin
                    st_next[j] = st_reg[j+1];
                end
                st_next[47] = rnd_val;
                t_next = cmd.step_last ? rnd_val + {3'b000, cmd.round_idx} : rnd_val;
            end
            OP_EMIT: begin
                for (int j = 0; j < 47; j++) begin
                    st_next[j] = st_reg[j+1];
                end
                st_next[47]    = st_reg[0];
                out_data_next  = st_reg[0];
                out_last_next  = cmd.step_last;
                out_valid_next = 1'b1;
            end
            OP_CLEAR: begin
                for (int j = 0; j < 16; j++) begin
                    ck_next[j] = 8'd0;
                end
                for (int j = 0; j < 48; j++) begin
                    st_next[j] = 8'd0;
                end
                chain_next = 8'd0;
                fill_next  = 4'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 16; j++) begin
                ck_reg[j] <= 8'd0;
            end
            for (int j = 0; j < 48; j++) begin
                st_reg[j] <= 8'd0;
            end
            chain_reg     <= 8'd0;
            fill_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            ck_reg        <= ck_next;
            st_reg        <= st_next;
            chain_reg     <= chain_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        blk_reg      <= blk_next;
        t_reg        <= t_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== hdl/md2_hash_engine.sv =====
// md2 hash engine top level: MD2 digest of a byte stream
// Input channel (s_): one item per transfer carrying an optional message byte
// (s_byte_valid) and an end-of-message mark (s_end_message).
// Output channel (m_): sixteen digest bytes, first byte first, m_last_byte on the last.
// Work per accepted item, from the accepting edge:
//   a byte that does not complete a 16-byte block: stored, next item right after
//   a byte that completes a block: 16 checksum steps, a fill step and the
//   864 substitutions of the compression loop; no new item is taken meanwhile
//   end of message: one more block (pad, checksum 16, fill, compression 864),
//   then the checksum block (fill, compression 864), 16 output transfers and
//   a clear step; a block completed by the end mark itself is compressed first
// The compression loop does one pi-table lookup per cycle on a rotating 48-byte
// state, which sets the rate.
// Reset (aresetn low, synchronous) clears the checksum, chain, state, byte count
// and output valid; s_ready rises in the first cycle after reset.
// A stalled receiver holds the digest: each byte waits in the output register until
// taken. After the clear step that follows the last byte, s_ready returns for a new message.
// Depends on md2_pkg, md2_ctrl, md2_datapath and md2_hash_engine_macros.svh.
`include "md2_hash_engine_macros.svh"

module md2_hash_engine
    import md2_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_byte_valid,
    input  logic       s_end_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_digest_byte,
    output logic       m_last_byte
);

    md2_cmd_t    cmd;
    md2_status_t status;
    logic        short_item;

    md2_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_valid  (s_byte_valid),
        .s_end_message (s_end_message),
        .status        (status),
        .cmd           (cmd)
    );

    md2_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_data_byte   (s_data_byte),
        .s_byte_valid  (s_byte_valid),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_byte (m_digest_byte),
        .m_last_byte   (m_last_byte)
    );

    // accepted item that neither completes a block nor ends the message
    assign short_item = s_valid && s_ready && !s_end_message
                        && !(s_byte_valid && status.fill_last);

    // a digest byte never overwrites one that is still waiting
    `MD2_ASSERT_NOW(a_emit_free, cmd.op == OP_EMIT, status.out_free, "emit into busy output")

    // input stays ready in the cycle after a byte that neither completes a block nor ends the message
    `MD2_ASSERT_NEXT(a_short_item, short_item, s_ready, "short item stalled input")

    // after the clear cycle the next message may start at once
    `MD2_ASSERT_NEXT(a_clear_idle, cmd.op == OP_CLEAR, s_ready && !status.fill_last, "clear not idle")

endmodule
